// ===== design/bpps_pkg.sv =====
// ----------------------------------------------------------------------------
// bpps_pkg
// Shared types, widths, register indexes and helpers of the point shader.
// ----------------------------------------------------------------------------
package bpps_pkg;

  localparam int COORD_W   = 24;   // Q8.16 coordinate
  localparam int NORM_W    = 16;   // Q2.14 unit vector component
  localparam int COLOR_W   = 16;   // Q1.15 color
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [COLOR_W-1:0] ONE_Q15 = 16'h8000;
  localparam int SPEC_EXP_DEFAULT = 20;

  // normalizer datapath
  localparam int VEC_W      = 25;  // difference of two coordinates
  localparam int MAG_W      = 24;  // magnitude of a difference
  localparam int SH_W       = $clog2(MAG_W);
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int SQRT_RW    = SUM_W + 1;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int UNIT_FRAC  = 14;
  localparam int NUM_W      = MAG_W + UNIT_FRAC + 1;
  localparam int DIV_STEPS  = UNIT_FRAC + 1;
  localparam int NORM_LAT   = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  // dot products and factors
  localparam int PROD_W = 2 * NORM_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int FACT_W = 19;
  localparam int SL_W   = 2 * COLOR_W;
  localparam int MIX_W  = SL_W + FACT_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z      = 3'd6;

  typedef logic [2:0][VEC_W-1:0]  vec_t;
  typedef logic [2:0][NORM_W-1:0] unit_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
    logic signed [COORD_W-1:0] lamp_x;
    logic signed [COORD_W-1:0] lamp_y;
    logic signed [COORD_W-1:0] lamp_z;
    logic [COLOR_W-1:0]        lamp_red;
    logic [COLOR_W-1:0]        lamp_green;
    logic [COLOR_W-1:0]        lamp_blue;
  } in_beat_t;

  typedef struct packed {
    logic [COLOR_W-1:0] shade_red;
    logic [COLOR_W-1:0] shade_green;
    logic [COLOR_W-1:0] shade_blue;
  } out_beat_t;

  // Q4.28 dot product to Q1.15 factor, negative and zero give zero
  function automatic logic [FACT_W-1:0] dot_to_q15(input logic signed [DOT_W-1:0] d);
    logic signed [DOT_W-1:0] t;
    t = (d + 34'sd4096) >>> 13;
    return (d > 0) ? t[FACT_W-1:0] : '0;
  endfunction

endpackage

// ===== design/blinn_phong_point_shader.sv =====
// ----------------------------------------------------------------------------
// blinn_phong_point_shader
// Shades one surface point for one point light, Blinn-Phong model.
// Path: input beat to result beat through two normalizers in series of
//   47 stages each (25-stage square root, 15-stage divider) and the power
//   chain.
// Throughput: one beat per cycle; the whole pipe holds while a result stalls.
// Reset: synchronous, clears the valid line and loads the register defaults.
// ----------------------------------------------------------------------------
module blinn_phong_point_shader
  import bpps_pkg::*;
#(
  parameter int SPECULAR_EXPONENT = SPEC_EXP_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Stage times, counted in register stages after the input beat.
  localparam int T_LC = 1 + NORM_LAT;            // L and V unit vectors
  localparam int T_B  = T_LC + 1;                // L+V, N*L products
  localparam int T_C  = T_B + 1;                 // N.L
  localparam int T_H  = T_B + NORM_LAT;          // halfway unit vector
  localparam int T_D  = T_H + 1;                 // N*H products
  localparam int T_E  = T_D + 1;                 // N.H
  localparam int T_F  = T_E + 1;                 // specular base
  localparam int T_P  = T_F + SPECULAR_EXPONENT; // specular power
  localparam int T_G  = T_P + 1;                 // factor, surface*lamp
  localparam int T_M  = T_G + 1;                 // full product
  localparam int LAT  = T_M + 1;                 // output register

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [COLOR_W-1:0]        surface_red;
  logic [COLOR_W-1:0]        surface_green;
  logic [COLOR_W-1:0]        surface_blue;
  logic                      surface_mode;
  logic signed [COORD_W-1:0] camera_x;
  logic signed [COORD_W-1:0] camera_y;
  logic signed [COORD_W-1:0] camera_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_red   <= ONE_Q15;
      surface_green <= ONE_Q15;
      surface_blue  <= ONE_Q15;
      surface_mode  <= 1'b0;
      camera_x      <= '0;
      camera_y      <= '0;
      camera_z      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SURFACE_RED:   surface_red   <= cfg_data[COLOR_W-1:0];
        REG_SURFACE_GREEN: surface_green <= cfg_data[COLOR_W-1:0];
        REG_SURFACE_BLUE:  surface_blue  <= cfg_data[COLOR_W-1:0];
        REG_SURFACE_MODE:  surface_mode  <= cfg_data[0];
        REG_CAMERA_X:      camera_x      <= $signed(cfg_data);
        REG_CAMERA_Y:      camera_y      <= $signed(cfg_data);
        REG_CAMERA_Z:      camera_z      <= $signed(cfg_data);
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: one global enable, the output register is the last stage
  // --------------------------------------------------------------------------
  logic           en;
  logic [LAT-1:0] vld_line;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_line[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_line <= '0;
    end else if (en) begin
      vld_line <= {vld_line[LAT-2:0], in_valid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: vectors to light and camera
  // --------------------------------------------------------------------------
  vec_t                    a_tl;
  vec_t                    a_tc;
  logic [2:0][NORM_W-1:0]  a_n;
  logic [2:0][COLOR_W-1:0] a_col;

  always_ff @(posedge clk) begin
    if (en) begin
      a_tl[0]  <= VEC_W'(in_data.lamp_x) - VEC_W'(in_data.point_x);
      a_tl[1]  <= VEC_W'(in_data.lamp_y) - VEC_W'(in_data.point_y);
      a_tl[2]  <= VEC_W'(in_data.lamp_z) - VEC_W'(in_data.point_z);
      a_tc[0]  <= VEC_W'(camera_x) - VEC_W'(in_data.point_x);
      a_tc[1]  <= VEC_W'(camera_y) - VEC_W'(in_data.point_y);
      a_tc[2]  <= VEC_W'(camera_z) - VEC_W'(in_data.point_z);
      a_n[0]   <= in_data.normal_x;
      a_n[1]   <= in_data.normal_y;
      a_n[2]   <= in_data.normal_z;
      a_col[0] <= in_data.lamp_red;
      a_col[1] <= in_data.lamp_green;
      a_col[2] <= in_data.lamp_blue;
    end
  end

  // L and V normalized side by side; V is only used in smooth mode
  unit_t l_unit;
  unit_t c_unit;

  bpps_norm u_norm_l (.clk(clk), .en(en), .vec(a_tl), .unit(l_unit));
  bpps_norm u_norm_c (.clk(clk), .en(en), .vec(a_tc), .unit(c_unit));

  // side data
  logic [2:0][NORM_W-1:0]  n_b;
  logic [2:0][NORM_W-1:0]  n_d;
  logic [2:0][COLOR_W-1:0] col_g;

  bpps_delay #(.WIDTH(3 * NORM_W), .DEPTH(T_LC - 1)) u_dly_nb (
    .clk(clk), .en(en), .d(a_n), .q(n_b)
  );
  bpps_delay #(.WIDTH(3 * NORM_W), .DEPTH(T_H - 1)) u_dly_nd (
    .clk(clk), .en(en), .d(a_n), .q(n_d)
  );
  bpps_delay #(.WIDTH(3 * COLOR_W), .DEPTH(T_P - 1)) u_dly_col (
    .clk(clk), .en(en), .d(a_col), .q(col_g)
  );

  // --------------------------------------------------------------------------
  // Stage B/C: halfway sum and N.L
  // --------------------------------------------------------------------------
  vec_t                    b_hs;
  logic signed [PROD_W-1:0] b_nl [3];
  logic signed [DOT_W-1:0]  c_ndl;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b_hs[i] <= VEC_W'($signed(l_unit[i])) + VEC_W'($signed(c_unit[i]));
        b_nl[i] <= $signed(n_b[i]) * $signed(l_unit[i]);
      end
      c_ndl <= DOT_W'(b_nl[0]) + DOT_W'(b_nl[1]) + DOT_W'(b_nl[2]);
    end
  end

  unit_t h_unit;

  bpps_norm u_norm_h (.clk(clk), .en(en), .vec(b_hs), .unit(h_unit));

  logic [DOT_W-1:0] ndl_g;

  bpps_delay #(.WIDTH(DOT_W), .DEPTH(T_P - T_C)) u_dly_ndl (
    .clk(clk), .en(en), .d(c_ndl), .q(ndl_g)
  );

  // --------------------------------------------------------------------------
  // Stage D/E/F: N.H to a saturated Q1.15 base
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] d_nh [3];
  logic signed [DOT_W-1:0]  e_nh;
  logic [COLOR_W-1:0]       f_base;
  logic [FACT_W-1:0]        nh_q15;

  assign nh_q15 = dot_to_q15(e_nh);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_nh[i] <= $signed(n_d[i]) * $signed(h_unit[i]);
      end
      e_nh   <= DOT_W'(d_nh[0]) + DOT_W'(d_nh[1]) + DOT_W'(d_nh[2]);
      f_base <= (nh_q15 > FACT_W'(ONE_Q15)) ? ONE_Q15 : nh_q15[COLOR_W-1:0];
    end
  end

  logic [COLOR_W-1:0] power;

  bpps_pow #(.EXPONENT(SPECULAR_EXPONENT)) u_pow (
    .clk(clk), .en(en), .base(f_base), .power(power)
  );

  // --------------------------------------------------------------------------
  // Stage G/M/O: factor, color products, round and clamp
  // --------------------------------------------------------------------------
  logic [2:0][COLOR_W-1:0] surf;
  logic [FACT_W-1:0]       diff;
  logic [FACT_W-1:0]       spec;
  logic [FACT_W-1:0]       g_factor;
  logic [2:0][SL_W-1:0]    g_sl;
  logic [2:0][MIX_W-1:0]   m_prod;
  logic [2:0][MIX_W-1:0]   rnd;
  logic [2:0][COLOR_W-1:0] shade;

  assign surf[0] = surface_red;
  assign surf[1] = surface_green;
  assign surf[2] = surface_blue;

  // specular only in smooth mode and only when the light faces the surface
  assign diff = dot_to_q15($signed(ndl_g));
  assign spec = (surface_mode && ($signed(ndl_g) > 0)) ? FACT_W'(power) : '0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i]   = (m_prod[i] + MIX_W'(1 << 29)) >> 30;
      shade[i] = (rnd[i] > MIX_W'(ONE_Q15)) ? ONE_Q15 : rnd[i][COLOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_factor <= diff + spec;
      for (int i = 0; i < 3; i++) begin
        g_sl[i]   <= SL_W'(surf[i]) * SL_W'(col_g[i]);
        m_prod[i] <= MIX_W'(g_sl[i]) * MIX_W'(g_factor);
      end
      out_data.shade_red   <= shade[0];
      out_data.shade_green <= shade[1];
      out_data.shade_blue  <= shade[2];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_out_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.shade_red <= ONE_Q15) && (out_data.shade_green <= ONE_Q15) &&
                  (out_data.shade_blue <= ONE_Q15))
    else $error("shade channel above 1.0");

  a_base_sat: assert property (@(posedge clk) disable iff (rst)
    vld_line[T_F-1] |-> (f_base <= ONE_Q15))
    else $error("specular base not saturated");

  a_power_range: assert property (@(posedge clk) disable iff (rst)
    vld_line[T_P-1] |-> (power <= ONE_Q15))
    else $error("specular power above 1.0");

  a_hold_line: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld_line) && $stable(g_factor))
    else $error("pipe moved during stall");

endmodule

// ===== design/bpps_delay.sv =====
// ----------------------------------------------------------------------------
// bpps_delay
// Enabled shift line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module bpps_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

// ===== design/bpps_norm.sv =====
// ----------------------------------------------------------------------------
// bpps_norm
// Pipelined vector normalizer: pre-shift, sum of squares, bit-per-stage
// square root, then a quotient bit per stage for the three components.
// ----------------------------------------------------------------------------
module bpps_norm
  import bpps_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  vec_t  vec,
  output unit_t unit
);

  // magnitudes and signs
  logic [2:0][MAG_W-1:0] mag1;
  logic [2:0]            neg1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= vec[i][VEC_W-1];
        mag1[i] <= vec[i][VEC_W-1] ? MAG_W'(-$signed(vec[i])) : vec[i][MAG_W-1:0];
      end
    end
  end

  // largest magnitude
  logic [MAG_W-1:0]      mx;
  logic [MAG_W-1:0]      mx2;
  logic [2:0][MAG_W-1:0] mag2;
  logic [2:0]            neg2;

  always_comb begin
    mx = mag1[0];
    if (mag1[1] > mx) mx = mag1[1];
    if (mag1[2] > mx) mx = mag1[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx2  <= mx;
      mag2 <= mag1;
      neg2 <= neg1;
    end
  end

  // shift so the largest magnitude has its top bit set
  logic [SH_W-1:0]       sh;
  logic [2:0][MAG_W-1:0] m3;
  logic [2:0]            neg3;
  logic                  zero3;

  always_comb begin
    sh = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (mx2[b]) sh = SH_W'(MAG_W - 1 - b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m3[i] <= mag2[i] << sh;
      end
      neg3  <= neg2;
      zero3 <= (mx2 == '0);
    end
  end

  // squares
  logic [2:0][SQ_W-1:0]  sq4;
  logic [2:0][MAG_W-1:0] m4;
  logic [2:0]            neg4;
  logic                  zero4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= SQ_W'(m3[i]) * SQ_W'(m3[i]);
      end
      m4    <= m3;
      neg4  <= neg3;
      zero4 <= zero3;
    end
  end

  // sum of squares
  logic [SUM_W-1:0]      sum5;
  logic [2:0][MAG_W-1:0] m5;
  logic [2:0]            neg5;
  logic                  zero5;

  always_ff @(posedge clk) begin
    if (en) begin
      sum5  <= SUM_W'(sq4[0]) + SUM_W'(sq4[1]) + SUM_W'(sq4[2]);
      m5    <= m4;
      neg5  <= neg4;
      zero5 <= zero4;
    end
  end

  // square root, one result bit per stage
  logic [SQRT_RW-1:0]    sx    [SQRT_STEPS];
  logic [SQRT_RW-1:0]    sr    [SQRT_STEPS];
  logic [2:0][MAG_W-1:0] sm    [SQRT_STEPS];
  logic [2:0]            sneg  [SQRT_STEPS];
  logic                  szero [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [SQRT_RW-1:0] BIT = SQRT_RW'(1) << (2 * (SQRT_STEPS - 1 - j));
    logic [SQRT_RW-1:0]    x_in;
    logic [SQRT_RW-1:0]    r_in;
    logic [SQRT_RW-1:0]    trial;
    logic [2:0][MAG_W-1:0] m_in;
    logic [2:0]            neg_in;
    logic                  zero_in;

    if (j == 0) begin : g_first
      assign x_in    = SQRT_RW'(sum5);
      assign r_in    = '0;
      assign m_in    = m5;
      assign neg_in  = neg5;
      assign zero_in = zero5;
    end else begin : g_next
      assign x_in    = sx[j-1];
      assign r_in    = sr[j-1];
      assign m_in    = sm[j-1];
      assign neg_in  = sneg[j-1];
      assign zero_in = szero[j-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (x_in >= trial) begin
          sx[j] <= x_in - trial;
          sr[j] <= (r_in >> 1) + BIT;
        end else begin
          sx[j] <= x_in;
          sr[j] <= r_in >> 1;
        end
        sm[j]    <= m_in;
        sneg[j]  <= neg_in;
        szero[j] <= zero_in;
      end
    end
  end

  // rounded numerators
  logic [ROOT_W-1:0]     len;
  logic [2:0][NUM_W-1:0] num6;
  logic [ROOT_W-1:0]     len6;
  logic [2:0]            neg6;
  logic                  zero6;

  assign len = sr[SQRT_STEPS-1][ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num6[i] <= NUM_W'({sm[SQRT_STEPS-1][i], UNIT_FRAC'(0)}) + NUM_W'(len >> 1);
      end
      len6  <= len;
      neg6  <= sneg[SQRT_STEPS-1];
      zero6 <= szero[SQRT_STEPS-1];
    end
  end

  // restoring division, one quotient bit per stage
  logic [2:0][NUM_W-1:0]     dr    [DIV_STEPS];
  logic [2:0][DIV_STEPS-1:0] dq    [DIV_STEPS];
  logic [ROOT_W-1:0]         dlen  [DIV_STEPS];
  logic [2:0]                dneg  [DIV_STEPS];
  logic                      dzero [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int K = DIV_STEPS - 1 - j;
    logic [2:0][NUM_W-1:0]     r_in;
    logic [2:0][DIV_STEPS-1:0] q_in;
    logic [ROOT_W-1:0]         len_in;
    logic [2:0]                neg_in;
    logic                      zero_in;
    logic [NUM_W-1:0]          dsub;

    if (j == 0) begin : g_first
      assign r_in    = num6;
      assign q_in    = '0;
      assign len_in  = len6;
      assign neg_in  = neg6;
      assign zero_in = zero6;
    end else begin : g_next
      assign r_in    = dr[j-1];
      assign q_in    = dq[j-1];
      assign len_in  = dlen[j-1];
      assign neg_in  = dneg[j-1];
      assign zero_in = dzero[j-1];
    end

    assign dsub = NUM_W'(len_in) << K;

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (r_in[i] >= dsub) begin
            dr[j][i]    <= r_in[i] - dsub;
            dq[j][i]    <= q_in[i] | (DIV_STEPS'(1) << K);
          end else begin
            dr[j][i]    <= r_in[i];
            dq[j][i]    <= q_in[i];
          end
        end
        dlen[j]  <= len_in;
        dneg[j]  <= neg_in;
        dzero[j] <= zero_in;
      end
    end
  end

  // signed result, zero vector gives zero
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dzero[DIV_STEPS-1]) begin
          unit[i] <= '0;
        end else if (dneg[DIV_STEPS-1][i]) begin
          unit[i] <= -NORM_W'(dq[DIV_STEPS-1][i]);
        end else begin
          unit[i] <= NORM_W'(dq[DIV_STEPS-1][i]);
        end
      end
    end
  end

endmodule

// ===== design/bpps_pow.sv =====
// ----------------------------------------------------------------------------
// bpps_pow
// Specular power: one rounded Q1.15 multiply per stage.
// ----------------------------------------------------------------------------
module bpps_pow
  import bpps_pkg::*;
#(
  parameter int EXPONENT = SPEC_EXP_DEFAULT
) (
  input  logic               clk,
  input  logic               en,
  input  logic [COLOR_W-1:0] base,
  output logic [COLOR_W-1:0] power
);

  logic [COLOR_W-1:0] pb [EXPONENT];
  logic [COLOR_W-1:0] pp [EXPONENT];

  for (genvar j = 0; j < EXPONENT; j++) begin : g_step
    logic [COLOR_W-1:0] b_in;
    logic [COLOR_W-1:0] p_in;
    logic [SL_W-1:0]    prod;

    if (j == 0) begin : g_first
      assign b_in = base;
      assign p_in = ONE_Q15;
    end else begin : g_next
      assign b_in = pb[j-1];
      assign p_in = pp[j-1];
    end

    assign prod = SL_W'(p_in) * SL_W'(b_in) + SL_W'(16384);

    always_ff @(posedge clk) begin
      if (en) begin
        pb[j] <= b_in;
        pp[j] <= prod[COLOR_W+14:15];
      end
    end
  end

  assign power = pp[EXPONENT-1];

endmodule

// ===== sim/blinn_phong_point_shader_tb.sv =====
// ----------------------------------------------------------------------------
// blinn_phong_point_shader_tb
// Self-checking bench for the point shader: directed corner beats, then
// random scenes under several register settings, with random idle on both
// sides. Each result beat is checked per channel against a local predictor.
// ----------------------------------------------------------------------------
module blinn_phong_point_shader_tb;
  import bpps_pkg::*;

  localparam int LATENCY    = 122;
  localparam int SETTLE     = LATENCY + 20;
  localparam int STUCK_MAX  = 4000;   // cycles with pending work but no beat
  localparam int SHOW_MAX   = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef longint trio_t [3];

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_beat_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // shadow registers of the shader
  logic [COLOR_W-1:0]        sh_red, sh_green, sh_blue;
  logic                      sh_smooth;
  logic signed [COORD_W-1:0] sh_cam_x, sh_cam_y, sh_cam_z;

  out_beat_t shades_due [$];
  int        mismatches = 0;
  int        stuck = 0;
  bit        quiet = 1'b0;      // no idling in the closing stretch

  blinn_phong_point_shader i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Q2.14 unit vector; magnitudes are pre-scaled so the largest reaches 2^23
  function automatic trio_t unit_of(trio_t v);
    longint unsigned m [3];
    longint unsigned mx, sum, len;
    trio_t u;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      u = '{0, 0, 0};
      return u;
    end
    while (mx < (64'd1 << 23)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      u[i] = longint'((m[i] * 16384 + (len >> 1)) / len);
      if (v[i] < 0) u[i] = -u[i];
    end
    return u;
  endfunction

  function automatic longint dot3(trio_t a, trio_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic longint unsigned q28_to_q15(longint d);
    if (d <= 0) return 0;
    return (unsigned'(d) + 4096) >> 13;
  endfunction

  function automatic logic [COLOR_W-1:0] lit_channel(logic [COLOR_W-1:0] surf,
                                                     logic [COLOR_W-1:0] lamp,
                                                     longint unsigned factor);
    longint unsigned x;
    x = (64'(surf) * lamp * factor + (64'd1 << 29)) >> 30;
    return (x > 32768) ? ONE_Q15 : x[COLOR_W-1:0];
  endfunction

  function automatic out_beat_t shade_point(in_beat_t b);
    trio_t to_lamp, to_cam, nrm, lvec, cvec, half, hvec;
    longint ndl;
    longint unsigned diff, spec, base, pw;
    out_beat_t r;
    to_lamp = '{longint'(b.lamp_x) - b.point_x, longint'(b.lamp_y) - b.point_y,
                longint'(b.lamp_z) - b.point_z};
    to_cam  = '{longint'(sh_cam_x) - b.point_x, longint'(sh_cam_y) - b.point_y,
                longint'(sh_cam_z) - b.point_z};
    nrm = '{longint'(b.normal_x), longint'(b.normal_y), longint'(b.normal_z)};
    lvec = unit_of(to_lamp);
    ndl = dot3(nrm, lvec);
    diff = q28_to_q15(ndl);
    spec = 0;
    // specular only on the lit side
    if (sh_smooth && ndl > 0) begin
      cvec = unit_of(to_cam);
      for (int i = 0; i < 3; i++) half[i] = lvec[i] + cvec[i];
      hvec = unit_of(half);
      base = q28_to_q15(dot3(nrm, hvec));
      if (base > 32768) base = 32768;
      pw = 32768;
      for (int i = 0; i < SPEC_EXP_DEFAULT; i++) pw = (pw * base + 16384) >> 15;
      spec = pw;
    end
    r.shade_red   = lit_channel(sh_red,   b.lamp_red,   diff + spec);
    r.shade_green = lit_channel(sh_green, b.lamp_green, diff + spec);
    r.shade_blue  = lit_channel(sh_blue,  b.lamp_blue,  diff + spec);
    return r;
  endfunction

  // ------------------------------------------------- result check + watchdog
  task automatic report(string chan, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= SHOW_MAX)
      $display("mismatch %s: expected %0d, got %0d", chan, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (shades_due.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("unexpected result beat %h", out_data);
        end else begin
          out_beat_t want;
          want = shades_due.pop_front();
          if (out_data.shade_red !== want.shade_red)
            report("red", want.shade_red, out_data.shade_red);
          if (out_data.shade_green !== want.shade_green)
            report("green", want.shade_green, out_data.shade_green);
          if (out_data.shade_blue !== want.shade_blue)
            report("blue", want.shade_blue, out_data.shade_blue);
        end
      end
      // watchdog: pending work with no beat moving
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) stuck = 0;
      else if (in_valid || shades_due.size() != 0) stuck++;
      if (stuck >= STUCK_MAX) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result side back-pressure in random bursts
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ stimulus side
  // drive one beat and hold it until accepted; valid stays high afterwards
  task automatic send_beat(in_beat_t b);
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    shades_due.push_back(shade_point(b));
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // the block is idle once every result is back and the pipe has emptied
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (shades_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SURFACE_RED:   sh_red    = val[COLOR_W-1:0];
      REG_SURFACE_GREEN: sh_green  = val[COLOR_W-1:0];
      REG_SURFACE_BLUE:  sh_blue   = val[COLOR_W-1:0];
      REG_SURFACE_MODE:  sh_smooth = val[0];
      REG_CAMERA_X:      sh_cam_x  = val;
      REG_CAMERA_Y:      sh_cam_y  = val;
      REG_CAMERA_Z:      sh_cam_z  = val;
      default: ;  // unused index, ignored by the block
    endcase
  endtask

  task automatic set_scene(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                           logic [COLOR_W-1:0] bl, bit smooth,
                           int cx, int cy, int cz);
    wait_idle();
    write_reg(REG_SURFACE_RED, CFG_W'(r));
    write_reg(REG_SURFACE_GREEN, CFG_W'(g));
    write_reg(REG_SURFACE_BLUE, CFG_W'(bl));
    write_reg(REG_SURFACE_MODE, CFG_W'(smooth));
    write_reg(REG_CAMERA_X, CFG_W'(cx));
    write_reg(REG_CAMERA_Y, CFG_W'(cy));
    write_reg(REG_CAMERA_Z, CFG_W'(cz));
  endtask

  function automatic in_beat_t make_beat(int px, int py, int pz,
                                         int nx, int ny, int nz,
                                         int lx, int ly, int lz,
                                         int cr, int cg, int cb);
    in_beat_t b;
    b.point_x = px;  b.point_y = py;  b.point_z = pz;
    b.normal_x = nx; b.normal_y = ny; b.normal_z = nz;
    b.lamp_x = lx;   b.lamp_y = ly;   b.lamp_z = lz;
    b.lamp_red = cr; b.lamp_green = cg; b.lamp_blue = cb;
    return b;
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(0, 4) == 0) return $signed($urandom() << 8) >>> 8;
    return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
  endfunction

  function automatic int rand_color();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, 32768);
  endfunction

  // mostly unit normals; some raw 16-bit noise
  function automatic in_beat_t rand_beat();
    in_beat_t b;
    real vx, vy, vz, mag;
    b = make_beat(rand_coord(), rand_coord(), rand_coord(), 0, 0, 0,
                  rand_coord(), rand_coord(), rand_coord(),
                  rand_color(), rand_color(), rand_color());
    if ($urandom_range(0, 7) == 0) begin
      b.normal_x = $urandom();
      b.normal_y = $urandom();
      b.normal_z = $urandom();
    end else begin
      do begin
        vx = $itor($urandom_range(0, 2000)) - 1000.0;
        vy = $itor($urandom_range(0, 2000)) - 1000.0;
        vz = $itor($urandom_range(0, 2000)) - 1000.0;
        mag = $sqrt(vx * vx + vy * vy + vz * vz);
      end while (mag < 1.0);
      b.normal_x = $rtoi(vx / mag * 16384.0);
      b.normal_y = $rtoi(vy / mag * 16384.0);
      b.normal_z = $rtoi(vz / mag * 16384.0);
    end
    return b;
  endfunction

  // --------------------------------------------------------------- test tasks
  localparam int ONE = 1 << 16;   // 1.0 in Q8.16
  localparam int NMAX = 16384;

  task automatic test_corners_rough();
    write_reg(REG_UNUSED, 24'hFFFFFF);   // must leave every register alone
    send_beat(make_beat(0, 0, 0, 0, 0, NMAX, 0, 0, 4 * ONE, 32768, 32768, 32768));
    send_beat(make_beat(0, 0, 0, 0, 0, -NMAX, 0, 0, 4 * ONE, 32768, 32768, 32768));
    // lamp on the point: zero-length light vector
    send_beat(make_beat(ONE, ONE, ONE, 0, NMAX, 0, ONE, ONE, ONE, 32768, 32768, 32768));
    send_beat(make_beat(-8388608, -8388608, -8388608, NMAX, 0, 0,
                        8388607, 8388607, 8388607, 65535, 0, 32768));
    send_beat(make_beat(8388607, 0, -8388608, -NMAX, NMAX, NMAX,
                        -8388608, 8388607, 0, 0, 65535, 1));
    // oversized normal: diffuse above 1.0 before the clamp
    send_beat(make_beat(0, 0, 0, 32767, 32767, 32767, ONE, ONE, ONE, 65535, 65535, 65535));
    send_beat(make_beat(0, 0, 0, -32768, -32768, -32768, -ONE, -ONE, -ONE, 40000, 20000, 1));
    send_beat(make_beat(3, -5, 7, 0, 0, NMAX, 3, -5, 8, 12345, 32768, 0));
  endtask

  task automatic test_corners_smooth();
    set_scene(16'd32768, 16'd16384, 16'hFFFF, 1'b1, -2 * ONE, 0, 0);
    // light and camera opposite: halfway vector is zero
    send_beat(make_beat(0, 0, 0, NMAX, 0, 0, 2 * ONE, 0, 0, 32768, 32768, 32768));
    // lit point, camera off the mirror direction
    send_beat(make_beat(0, 0, 0, 0, NMAX, 0, ONE, ONE, 0, 32768, 32768, 32768));
    send_beat(make_beat(-2 * ONE, ONE, 0, 0, NMAX, 0, -4 * ONE, 3 * ONE, 0,
                        32768, 32768, 32768));
    // camera on the point: zero-length view vector
    send_beat(make_beat(-2 * ONE, 0, 0, 0, NMAX, 0, 0, 5 * ONE, 0, 32768, 10000, 65535));
    // back-lit: no specular
    send_beat(make_beat(0, 0, 0, 0, -NMAX, 0, ONE, ONE, 0, 32768, 32768, 32768));
    send_beat(make_beat(0, 0, 0, 32767, 32767, 32767, ONE, 2 * ONE, 3 * ONE,
                        65535, 65535, 65535));
    send_beat(make_beat(8388607, 8388607, 8388607, -NMAX, 0, 0,
                        -8388608, 8388607, 8388607, 32768, 32768, 32768));
  endtask

  task automatic test_random_scenes(int beats);
    repeat (beats) begin
      send_beat(rand_beat());
      maybe_gap();
    end
  endtask

  // sender holds off until the pipe has drained completely
  task automatic test_drain_pause();
    test_random_scenes(20);
    in_valid <= 1'b0;
    while (shades_due.size() != 0) @(posedge clk);
    test_random_scenes(20);
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    sh_red = ONE_Q15;  sh_green = ONE_Q15;  sh_blue = ONE_Q15;
    sh_smooth = 1'b0;
    sh_cam_x = '0;     sh_cam_y = '0;       sh_cam_z = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corners_rough();
    test_corners_smooth();
    test_random_scenes(150);
    set_scene(16'd0, 16'd32768, 16'd7, 1'b0, 8388607, -8388608, 8388607);
    test_random_scenes(100);
    set_scene(16'd20000, 16'd32768, 16'd0, 1'b1, 0, 0, 5 * ONE);
    test_drain_pause();
    test_random_scenes(120);
    set_scene(16'hFFFF, 16'd1, 16'd32768, 1'b1, -8388608, 8388607, -8388608);
    test_random_scenes(100);
    set_scene($urandom_range(0, 32768), $urandom_range(0, 32768),
              $urandom_range(0, 32768), 1'b1, rand_coord(), rand_coord(), rand_coord());
    test_random_scenes(60);
    quiet = 1'b1;
    test_random_scenes(100);

    in_valid <= 1'b0;
    while (shades_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bpps_pkg.sv
design/bpps_delay.sv
design/bpps_norm.sv
design/bpps_pow.sv
design/blinn_phong_point_shader.sv
sim/blinn_phong_point_shader_tb.sv
